// ----- hdl/ssh_pkg.sv -----
// Shared constants and types for the strongest-sensor selector.
`default_nettype none

package ssh_pkg;

	// Fixed field widths of the request and result channels.
	localparam int unsigned FIELD_W   = 10;
	localparam int unsigned NUM_FIELDS = 12;
	localparam int unsigned CHOSEN_W  = 4;

	// Defaults for the top-level parameters.
	localparam int unsigned NUM_SENSORS_DEF  = 12;
	localparam int unsigned SAMPLE_WIDTH_DEF = 10;

	// Configuration register map.
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = FIELD_W;
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCH_MARGIN    = 1'd1;

	// Register reset values.
	localparam logic [FIELD_W-1:0] THRESHOLD_RST = 10'd50;
	localparam logic [FIELD_W-1:0] MARGIN_RST    = 10'd30;

	// Winner of the lane merge: best candidate of one frame.
	typedef struct packed {
		logic                found;
		logic [CHOSEN_W-1:0] idx;
		logic [FIELD_W-1:0]  value;
	} best_t;

endpackage

`default_nettype wire

// ----- hdl/ssh_sensor_if.sv -----
// Request channel carrying one frame of sensor readings.
`default_nettype none

interface ssh_sensor_if;
	logic                         valid;
	logic                         ready;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_0;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_1;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_2;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_3;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_4;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_5;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_6;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_7;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_8;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_9;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_10;
	logic [ssh_pkg::FIELD_W-1:0]  sensor_11;

	modport source (
		output valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, sensor_5,
		       sensor_6, sensor_7, sensor_8, sensor_9, sensor_10, sensor_11,
		input  ready
	);

	modport sink (
		input  valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, sensor_5,
		       sensor_6, sensor_7, sensor_8, sensor_9, sensor_10, sensor_11,
		output ready
	);
endinterface

`default_nettype wire

// ----- hdl/ssh_result_if.sv -----
// Result channel carrying the selected direction.
`default_nettype none

interface ssh_result_if;
	logic                          valid;
	logic                          ready;
	logic                          direction_found;
	logic [ssh_pkg::CHOSEN_W-1:0]  chosen_sensor;

	modport source (
		output valid, direction_found, chosen_sensor,
		input  ready
	);

	modport sink (
		input  valid, direction_found, chosen_sensor,
		output ready
	);
endinterface

`default_nettype wire

// ----- hdl/ssh_lane.sv -----
// One sensor lane: trims the reading and tests it against the threshold.
`default_nettype none

module ssh_lane #(
	parameter int unsigned SAMPLE_WIDTH = ssh_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic [ssh_pkg::FIELD_W-1:0] field,
	input  wire logic [ssh_pkg::FIELD_W-1:0] threshold,
	output logic [((SAMPLE_WIDTH < ssh_pkg::FIELD_W) ? SAMPLE_WIDTH : ssh_pkg::FIELD_W)-1:0]
	             reading,
	output logic                             candidate
);

	localparam int unsigned FW   = ssh_pkg::FIELD_W;
	localparam int unsigned RD_W = (SAMPLE_WIDTH < FW) ? SAMPLE_WIDTH : FW;

	// The reading is the low bits of the field; it counts only when strictly
	// above the threshold.
	always_comb begin
		reading   = field[RD_W-1:0];
		candidate = (FW'(reading) > threshold);
	end

endmodule

`default_nettype wire

// ----- hdl/ssh_merge.sv -----
// Compare tree over the lanes: largest candidate, lowest index on a tie.
`default_nettype none

module ssh_merge #(
	parameter int unsigned NUM_SENSORS = ssh_pkg::NUM_SENSORS_DEF,
	parameter int unsigned RD_W        = ssh_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic [RD_W-1:0] reading [NUM_SENSORS],
	input  wire logic            candidate [NUM_SENSORS],
	output ssh_pkg::best_t       best
);

	localparam int unsigned IDX_W  = $clog2(NUM_SENSORS);
	localparam int unsigned LEAVES = 1 << IDX_W;
	localparam int unsigned NODES  = 2 * LEAVES - 1;

	logic             node_v   [NODES];
	logic [RD_W-1:0]  node_val [NODES];
	logic [IDX_W-1:0] node_idx [NODES];

	// Leaves hold the lanes; each inner node keeps the better of its children,
	// the left (lower index) child winning unless the right one is strictly larger.
	always_comb begin
		for (int i = 0; i < LEAVES; i++) begin
			if (i < NUM_SENSORS) begin
				node_v[LEAVES-1+i]   = candidate[i];
				node_val[LEAVES-1+i] = reading[i];
			end else begin
				node_v[LEAVES-1+i]   = 1'b0;
				node_val[LEAVES-1+i] = '0;
			end
			node_idx[LEAVES-1+i] = IDX_W'(i);
		end
		for (int k = LEAVES - 2; k >= 0; k--) begin
			if (node_v[2*k+2] && (!node_v[2*k+1] || (node_val[2*k+2] > node_val[2*k+1]))) begin
				node_v[k]   = 1'b1;
				node_val[k] = node_val[2*k+2];
				node_idx[k] = node_idx[2*k+2];
			end else begin
				node_v[k]   = node_v[2*k+1];
				node_val[k] = node_val[2*k+1];
				node_idx[k] = node_idx[2*k+1];
			end
		end
	end

	// Root of the tree is the frame's winner.
	always_comb begin
		best.found = node_v[0];
		best.idx   = ssh_pkg::CHOSEN_W'(node_idx[0]);
		best.value = ssh_pkg::FIELD_W'(node_val[0]);
	end

endmodule

`default_nettype wire

// ----- hdl/strongest_sensor_hysteresis.sv -----
// Top level of the strongest-sensor selector with threshold and hysteresis.
// Each request is one frame of readings and yields exactly one result: the index
// of the strongest reading strictly above detect_threshold (lowest index on a
// tie), or "no direction" when none qualifies. While a sensor is held, the block
// moves to a new one only if the new maximum exceeds the held sensor's current
// reading plus switch_margin. The block takes one frame per clock cycle while the
// result channel does not stall it, and carries each frame through its stages: the
// first stage runs the per-sensor lanes and the compare tree, the second applies hysteresis against
// the held choice and is the output register, so the held state is always up
// to date for the next frame. Write the configuration registers only while idle.
`default_nettype none

module strongest_sensor_hysteresis #(
	parameter int unsigned NUM_SENSORS  = ssh_pkg::NUM_SENSORS_DEF,
	parameter int unsigned SAMPLE_WIDTH = ssh_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	ssh_sensor_if.sink                          sensors,
	ssh_result_if.source                        result,
	input  wire logic                           write_en,
	input  wire logic [ssh_pkg::CFG_IDX_W-1:0]  reg_index,
	input  wire logic [ssh_pkg::CFG_DATA_W-1:0] write_data
);

	localparam int unsigned FW    = ssh_pkg::FIELD_W;
	localparam int unsigned RD_W  = (SAMPLE_WIDTH < FW) ? SAMPLE_WIDTH : FW;
	localparam int unsigned IDX_W = $clog2(NUM_SENSORS);

	logic [FW-1:0]   field [ssh_pkg::NUM_FIELDS];
	logic [RD_W-1:0] reading [NUM_SENSORS];
	logic            candidate [NUM_SENSORS];
	ssh_pkg::best_t  best;

	logic [FW-1:0]   threshold_q;
	logic [FW-1:0]   margin_q;

	logic            valid_s1;
	logic [RD_W-1:0] rd_s1 [NUM_SENSORS];
	ssh_pkg::best_t  best_s1;

	logic                         valid_s2;
	logic                         found_s2;
	logic [ssh_pkg::CHOSEN_W-1:0] chosen_s2;

	logic             held_valid_q;
	logic [IDX_W-1:0] held_idx_q;

	logic             advance;
	logic             in_acc;
	logic [RD_W-1:0]  held_rd;
	logic [FW:0]      held_sum;
	logic             do_switch;
	logic             keep_held;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ssh_pkg::THRESHOLD_RST;
			margin_q    <= ssh_pkg::MARGIN_RST;
		end else if (write_en) begin
			case (reg_index)
				ssh_pkg::REG_DETECT_THRESHOLD: threshold_q <= write_data;
				ssh_pkg::REG_SWITCH_MARGIN:    margin_q    <= write_data;
				default: ;
			endcase
		end
	end

	// Gather the request fields into an array for the lanes.
	always_comb begin
		field[0]  = sensors.sensor_0;
		field[1]  = sensors.sensor_1;
		field[2]  = sensors.sensor_2;
		field[3]  = sensors.sensor_3;
		field[4]  = sensors.sensor_4;
		field[5]  = sensors.sensor_5;
		field[6]  = sensors.sensor_6;
		field[7]  = sensors.sensor_7;
		field[8]  = sensors.sensor_8;
		field[9]  = sensors.sensor_9;
		field[10] = sensors.sensor_10;
		field[11] = sensors.sensor_11;
	end

	// One lane per sensor in use.
	for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
		ssh_lane #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_lane (
			.field    (field[g]),
			.threshold(threshold_q),
			.reading  (reading[g]),
			.candidate(candidate[g])
		);
	end

	ssh_merge #(
		.NUM_SENSORS(NUM_SENSORS),
		.RD_W       (RD_W)
	) u_merge (
		.reading  (reading),
		.candidate(candidate),
		.best     (best)
	);

	// Pipeline moves when the output register is free or being drained.
	assign advance       = !valid_s2 || result.ready;
	assign sensors.ready = advance || !valid_s1;
	assign in_acc        = sensors.valid && sensors.ready;

	// Stage 1: lane readings and the tree winner.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1   <= reading;
			best_s1 <= best;
		end
	end

	// Hysteresis: switch only if the new maximum beats the held reading plus
	// the margin; the sum is one bit wider so it never wraps.
	always_comb begin
		held_rd   = rd_s1[held_idx_q];
		held_sum  = (FW + 1)'(held_rd) + (FW + 1)'(margin_q);
		do_switch = ((FW + 1)'(best_s1.value) > held_sum);
		keep_held = held_valid_q && !do_switch;
	end

	// Stage 2: output register and held choice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			held_valid_q <= 1'b0;
			held_idx_q   <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				if (!best_s1.found) begin
					held_valid_q <= 1'b0;
					held_idx_q   <= '0;
				end else begin
					held_valid_q <= 1'b1;
					if (!keep_held) begin
						held_idx_q <= best_s1.idx[IDX_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			found_s2 <= best_s1.found;
			if (!best_s1.found) begin
				chosen_s2 <= '0;
			end else if (keep_held) begin
				chosen_s2 <= ssh_pkg::CHOSEN_W'(held_idx_q);
			end else begin
				chosen_s2 <= best_s1.idx;
			end
		end
	end

	assign result.valid           = valid_s2;
	assign result.direction_found = found_s2;
	assign result.chosen_sensor   = chosen_s2;

	// A held choice always names a sensor in use.
	a_held_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> (32'(held_idx_q) < NUM_SENSORS))
		else $error("held sensor index out of range");

	// No direction means the index reads as zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.direction_found) |-> (result.chosen_sensor == '0))
		else $error("nonzero index without a direction");

	// A reported direction names a sensor in use.
	a_chosen_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.direction_found) |-> (32'(result.chosen_sensor) < NUM_SENSORS))
		else $error("chosen sensor out of range");

	// The held choice after a result is exactly what that result reported.
	a_held_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1) |=>
			((held_valid_q == result.direction_found) &&
			 (ssh_pkg::CHOSEN_W'(held_idx_q) == result.chosen_sensor)))
		else $error("held choice differs from last result");

endmodule

`default_nettype wire
